// ===== src/bgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bgcd_pkg
// Shared widths and the command and status bundles that pass between the
// binary gcd controller and datapath.
// ----------------------------------------------------------------------------
package bgcd_pkg;

	// field widths on the stream ports
	localparam int OPER_W  = 32;
	localparam int GCD_W   = 32;
	localparam int S_TDATA_W = 2 * OPER_W;
	localparam int M_TDATA_W = GCD_W;

	// controller to datapath
	typedef struct packed {
		logic load;   // take a new operand pair
		logic step;   // run one reduction step
		logic emit;   // write the shifted result into the output register
	} bgcd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;   // pair has settled or the step bound is reached
	} bgcd_status_t;

endpackage

// ===== src/binary_gcd_unit.sv =====
// ----------------------------------------------------------------------------
// binary_gcd_unit
// Greatest common divisor of two unsigned operands by the binary method.
//
// Input channel s_*: one item carries operand_a and operand_b. The unit
// takes one item at a time; s_tready is high only while no item is in work.
// Output channel m_*: one item per input item, carrying gcd_value.
// Equal operands give that value, a zero operand gives the other one, and
// both zero give zero.
// Sequence: the load happens at the accepting edge, then k reduction steps
// with k <= 2*WIDTH+1 (at most 65 for WIDTH 32), then the write of the
// output register, after which the result is offered; each step halves
// one or both values or subtracts and halves.
// The next item can be taken in the cycle after the result is written, even
// while the result still waits; no item is taken before the last is written.
// When the receiver stalls with a result pending, a finished item holds in
// the datapath until the output register frees up.
// Reset clears the controller and the output valid flag; no item survives.
// ----------------------------------------------------------------------------
module binary_gcd_unit #(
	parameter int WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// operand_a [31:0], operand_b [63:32]
	input  logic [bgcd_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// gcd_value [31:0]
	output logic [bgcd_pkg::M_TDATA_W-1:0]  m_tdata
);

	bgcd_pkg::bgcd_cmd_t    cmd;
	bgcd_pkg::bgcd_status_t status;

	// controller
	bgcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	bgcd_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operand_a (s_tdata[bgcd_pkg::OPER_W-1:0]),
		.operand_b (s_tdata[2*bgcd_pkg::OPER_W-1:bgcd_pkg::OPER_W]),
		.status    (status),
		.gcd_value (m_tdata)
	);

endmodule

// ===== src/bgcd_dp.sv =====
// ----------------------------------------------------------------------------
// bgcd_dp
// Operand registers, shared-factor count, step counter and output register
// for the binary gcd; one reduction step per cycle under controller command.
// ----------------------------------------------------------------------------
module bgcd_dp #(
	parameter int WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bgcd_pkg::bgcd_cmd_t        cmd,
	input  logic [bgcd_pkg::OPER_W-1:0] operand_a,
	input  logic [bgcd_pkg::OPER_W-1:0] operand_b,
	output bgcd_pkg::bgcd_status_t     status,
	output logic [bgcd_pkg::GCD_W-1:0]  gcd_value
);

	localparam int STEP_LIMIT = 2 * WIDTH + 1;
	localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
	localparam int TWOS_W     = $clog2(WIDTH + 1);

	logic [WIDTH-1:0]  x_q, y_q, out_q;
	logic [TWOS_W-1:0] twos_q;
	logic [STEP_W-1:0] step_q;

	logic [WIDTH-1:0] x_nxt, y_nxt, diff_xy, diff_yx, res_w;
	logic             twos_inc, eq_xy, x_zero, y_zero, at_limit;

	// settle checks
	assign eq_xy    = (x_q == y_q);
	assign x_zero   = (x_q == '0);
	assign y_zero   = (y_q == '0);
	assign at_limit = (step_q == STEP_W'(STEP_LIMIT));
	assign status.done = eq_xy | x_zero | y_zero | at_limit;

	// value left once settled: y only when x ran to zero first, x at the bound
	assign res_w = (!at_limit && !eq_xy && x_zero) ? y_q : x_q;

	// one reduction step
	assign diff_xy = x_q - y_q;
	assign diff_yx = y_q - x_q;
	always_comb begin
		x_nxt    = x_q;
		y_nxt    = y_q;
		twos_inc = 1'b0;
		if (!x_q[0] && !y_q[0]) begin
			x_nxt    = x_q >> 1;
			y_nxt    = y_q >> 1;
			twos_inc = 1'b1;
		end else if (!x_q[0]) begin
			x_nxt = x_q >> 1;
		end else if (!y_q[0]) begin
			y_nxt = y_q >> 1;
		end else if (x_q > y_q) begin
			x_nxt = diff_xy >> 1;
		end else begin
			x_nxt = diff_yx >> 1;
			y_nxt = x_q;
		end
	end

	// working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			twos_q <= '0;
			step_q <= '0;
		end else if (cmd.load) begin
			x_q    <= WIDTH'(operand_a);
			y_q    <= WIDTH'(operand_b);
			twos_q <= '0;
			step_q <= '0;
		end else if (cmd.step) begin
			x_q    <= x_nxt;
			y_q    <= y_nxt;
			twos_q <= twos_q + TWOS_W'(twos_inc);
			step_q <= step_q + STEP_W'(1);
		end
	end

	// output register, shared factors of two restored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (cmd.emit) begin
			out_q <= res_w << twos_q;
		end
	end

	assign gcd_value = bgcd_pkg::GCD_W'(out_q);

endmodule

// ===== src/bgcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bgcd_ctrl
// Controller for the binary gcd: input handshake, step sequencing and the
// valid flag of the output register.
// ----------------------------------------------------------------------------
module bgcd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  bgcd_pkg::bgcd_status_t status,
	output bgcd_pkg::bgcd_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0] state_q, state_nxt;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!status.done) begin
					cmd.step = 1'b1;
				end else if (slot_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end else begin
					state_nxt = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/bgcd_chk.sv =====
// ----------------------------------------------------------------------------
// bgcd_chk
// Port-level checks for binary_gcd_unit, attached by bind.
// ----------------------------------------------------------------------------
module bgcd_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [bgcd_pkg::M_TDATA_W-1:0]  m_tdata
);

	// one item in work at a time: no accept right after an accept
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("bgcd: input taken again while an item is in work");

	// reset leaves no result pending
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("bgcd: result valid during reset");

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("bgcd: result dropped while stalled");

	// a stalled result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("bgcd: result changed while stalled");

endmodule

bind binary_gcd_unit bgcd_chk u_bgcd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_gcd_unit. Operand pairs go in on the s_*
// stream and every gcd that comes back on m_* is compared with a table value
// or a local model of the binary method. A short directed table comes first,
// then random pairs in three traffic phases, with a long output stall and two
// drain pauses.
`timescale 1ns / 100ps

module tb;

	localparam int OPER_W     = bgcd_pkg::OPER_W;
	localparam int STEP_BOUND = 2 * OPER_W + 1;
	localparam int CYCLE_CAP  = 500000;
	localparam int DRAIN_WAIT = 80;
	localparam int HOLD_LEN   = 400;
	localparam int RAND_ITEMS = 450;

	typedef logic [OPER_W-1:0] word_t;

	// one row of the directed table
	typedef struct {
		word_t a;
		word_t b;
		bit    known;
		word_t gcd;
	} gcd_row_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b1;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	// operand_a [31:0], operand_b [63:32]
	logic [bgcd_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	// gcd_value [31:0]
	logic [bgcd_pkg::M_TDATA_W-1:0] m_tdata;

	word_t gcd_expected_q[$];
	int    send_idle_pct = 0;
	int    recv_idle_pct = 0;
	int    hold_request  = 0;
	int    error_count   = 0;
	int    items_sent    = 0;
	int    gcds_checked  = 0;
	int    cycle_count   = 0;

	gcd_row_t directed_rows[] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		'{32'h1234_5678, 32'h0000_0000, 1'b1, 32'h1234_5678},
		'{32'h0000_0007, 32'h0000_0007, 1'b1, 32'h0000_0007},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		'{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0001},
		'{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
		'{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000},
		'{32'h8000_0000, 32'h0000_0001, 1'b1, 32'h0000_0001},
		'{32'h8000_0000, 32'h4000_0000, 1'b1, 32'h4000_0000},
		'{32'hFFFF_FFFE, 32'h0000_0002, 1'b1, 32'h0000_0002},
		'{32'h0000_000C, 32'h0000_0012, 1'b1, 32'h0000_0006},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'h5555_5555},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'h0},
		'{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0},
		'{32'hDEAD_BEEF, 32'hCAFE_BABE, 1'b0, 32'h0},
		'{32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b0, 32'h0},
		'{32'h8000_0000, 32'hC000_0000, 1'b0, 32'h0},
		'{32'h0000_0003, 32'h8000_0000, 1'b0, 32'h0},
		'{32'h0000_0030, 32'h0000_00B4, 1'b0, 32'h0},
		'{32'h9E37_79B9, 32'h6135_4A71, 1'b0, 32'h0}
	};

	binary_gcd_unit #(.WIDTH(OPER_W)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// binary gcd: strip shared twos, reduce, shift the twos back in
	function automatic word_t stein_gcd(word_t a, word_t b);
		word_t x;
		word_t y;
		word_t res;
		int    twos;
		bit    settled;
		x       = a;
		y       = b;
		res     = a;
		twos    = 0;
		settled = 1'b0;
		for (int n = 0; n < STEP_BOUND; n++) begin
			if (!settled) begin
				if (x == y) begin
					res     = x;
					settled = 1'b1;
				end else if (x == '0) begin
					res     = y;
					settled = 1'b1;
				end else if (y == '0) begin
					res     = x;
					settled = 1'b1;
				end else begin
					if (!x[0] && !y[0]) begin
						x    = x >> 1;
						y    = y >> 1;
						twos = twos + 1;
					end else if (!x[0]) begin
						x = x >> 1;
					end else if (!y[0]) begin
						y = y >> 1;
					end else if (x > y) begin
						x = (x - y) >> 1;
					end else begin
						res = (y - x) >> 1;
						y   = x;
						x   = res;
					end
					res = x;
				end
			end
		end
		if (twos > 63)
			twos = 63;
		return res << twos;
	endfunction

	// random operand pair: plain random, shared-factor, power-of-two, small, equal or zero, or consecutive
	task automatic pick_pair(output word_t a, output word_t b);
		word_t g;
		case ($urandom_range(9))
			0, 1, 2: begin
				a = $urandom;
				b = $urandom;
			end
			3, 4: begin
				g = $urandom_range(1, 65535) << $urandom_range(0, 12);
				a = g * $urandom_range(1, 65535);
				b = g * $urandom_range(1, 65535);
			end
			5: begin
				a = word_t'(1) << $urandom_range(31);
				b = word_t'($urandom) << $urandom_range(31);
			end
			6: begin
				a = $urandom_range(0, 15);
				b = $urandom_range(0, 15);
			end
			7: begin
				a = $urandom;
				b = ($urandom_range(1) == 1) ? a : '0;
				if ($urandom_range(1) == 1) begin
					g = a;
					a = b;
					b = g;
				end
			end
			default: begin
				a = $urandom;
				b = a + 1;
			end
		endcase
	endtask

	// offer one item, with random gaps in front, until it is taken
	task automatic send_pair(word_t a, word_t b, bit known, word_t gcd);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		gcd_expected_q.insert(gcd_expected_q.size(), known ? gcd : stein_gcd(a, b));
		items_sent++;
	endtask

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// output side: random stalls plus a long requested hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				m_tready  <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// compare each gcd with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (gcd_expected_q.size() == 0) begin
				$display("%0t: unexpected gcd item, actual %h", $time, m_tdata);
				error_count++;
			end else begin
				if (m_tdata !== gcd_expected_q[0]) begin
					$display("%0t: gcd mismatch, expected %h actual %h",
						$time, gcd_expected_q[0], m_tdata);
					error_count++;
				end
				void'(gcd_expected_q.pop_front());
				gcds_checked++;
			end
		end
	end

	// run time cap
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// stimulus
	initial begin
		word_t a;
		word_t b;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, sender mostly offering and receiver mostly stalled
		send_idle_pct = 22;
		recv_idle_pct = 83;
		foreach (directed_rows[i])
			send_pair(directed_rows[i].a, directed_rows[i].b,
				directed_rows[i].known, directed_rows[i].gcd);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 3) begin
				send_idle_pct = 83;
				recv_idle_pct = 22;
			end else if (n == 2 * RAND_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// hold the sender until the pipe is empty
			if (n == RAND_ITEMS / 6 || n == RAND_ITEMS / 2) begin
				s_tvalid <= 1'b0;
				wait (gcd_expected_q.size() == 0);
				@(posedge clk);
			end
			// long output stall while items keep coming
			if (n == 2 * RAND_ITEMS / 3 + 20)
				hold_request = HOLD_LEN;
			pick_pair(a, b);
			send_pair(a, b, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		wait (gcd_expected_q.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("tb: %0d operand pairs sent, %0d gcd items checked", items_sent,
			gcds_checked);
		$display("tb: zero, equal, extreme, shared-factor and random pairs");
		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bgcd_pkg.sv
src/bgcd_dp.sv
src/bgcd_ctrl.sv
src/binary_gcd_unit.sv
src/bgcd_chk.sv
tb/tb.sv
